// ----- rtl/core/dad_pkg.sv -----
`timescale 1ns / 1ps
// dad_pkg: widths, limits and the month-length table for date_add_days.
// No dependencies; used by dad_ctrl, dad_dp and date_add_days.
package dad_pkg;

    localparam int YEAR_W   = 14;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int ADD_W    = 16;
    // Walked year can run past 16383 by up to about 180; day sum needs one more bit.
    localparam int WYEAR_W  = YEAR_W + 1;
    localparam int WDAY_W   = ADD_W + 1;

    localparam logic [WYEAR_W-1:0] YEAR_MAX = WYEAR_W'(9999);
    localparam logic [MONTH_W-1:0] JANUARY  = MONTH_W'(1);
    localparam logic [MONTH_W-1:0] FEBRUARY = MONTH_W'(2);
    localparam logic [MONTH_W-1:0] DECEMBER = MONTH_W'(12);

    typedef struct packed {
        logic load_in;   // take a new date into the walk registers
        logic step;      // subtract one month length and advance the month
        logic load_out;  // copy the finished date into the result register
    } dad_cmd_t;

    typedef struct packed {
        logic fits;      // current day fits within the current month
    } dad_stat_t;

    // Length of a month; leap is set when the walked year is divisible by 4.
    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] month,
                                                    input logic leap);
        logic [DAY_W-1:0] len;
        begin
            unique case (month)
                4'd2:                      len = leap ? DAY_W'(29) : DAY_W'(28);
                4'd4, 4'd6, 4'd9, 4'd11:   len = DAY_W'(30);
                default:                   len = DAY_W'(31);
            endcase
            return len;
        end
    endfunction

endpackage

// ----- rtl/core/date_add_days.sv -----
`timescale 1ns / 1ps
// date_add_days: adds a day count to a calendar date, walking one month per cycle.
// Depends on dad_pkg, dad_ctrl, dad_dp.
//
//  channel | handshake                  | fields
//  --------+----------------------------+-------------------------------------------
//  in      | in_valid / in_stall        | start_year, start_month, start_day,
//          |                            | days_to_add
//  out     | out_valid / out_stall      | end_year, end_month, end_day, year_overflow
//
// Walk: the month-subtract loop in dad_dp takes one month per cycle through M
//   months, where M is the number of months walked (about days/30, at most about
//   2200 for 65535 days); out_valid rises after the walk and hand-off, and the
//   next item is accepted only after the sequencer returns to idle.
// One item is in the walk at a time; in_stall is high from acceptance until the
//   result moves into the output register.
// The output register holds a finished result under out_stall while the next
//   item is accepted and walked; a walk that ends with the register still full
//   waits for it to drain.
// Reset (rst_n, async, active low) clears the sequencer and out_valid only.
module date_add_days
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [dad_pkg::YEAR_W-1:0]    start_year,
    input  logic [dad_pkg::MONTH_W-1:0]   start_month,
    input  logic [dad_pkg::DAY_W-1:0]     start_day,
    input  logic [dad_pkg::ADD_W-1:0]     days_to_add,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [dad_pkg::YEAR_W-1:0]    end_year,
    output logic [dad_pkg::MONTH_W-1:0]   end_month,
    output logic [dad_pkg::DAY_W-1:0]     end_day,
    output logic                          year_overflow
);

    dad_pkg::dad_cmd_t  cmd;
    dad_pkg::dad_stat_t stat;

    // Sequencer: idle -> walk (step until the day fits) -> hand off, or hold until the result register frees.
    dad_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Walk registers and result register.
    dad_dp u_dp
    (
        .clk           (clk),
        .start_year    (start_year),
        .start_month   (start_month),
        .start_day     (start_day),
        .days_to_add   (days_to_add),
        .cmd           (cmd),
        .stat          (stat),
        .end_year      (end_year),
        .end_month     (end_month),
        .end_day       (end_day),
        .year_overflow (year_overflow)
    );

endmodule

// ----- rtl/core/dad_ctrl.sv -----
`timescale 1ns / 1ps
// dad_ctrl: sequencer for date_add_days; loads, walks months, hands off result.
// Depends on dad_pkg.
module dad_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    output logic              out_valid,
    input  logic              out_stall,
    input  dad_pkg::dad_stat_t stat,
    output dad_pkg::dad_cmd_t  cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_HOLD
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   slot_free;

    // Result register can take a new date when empty or being drained this cycle.
    assign slot_free = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd            = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (!stat.fits)
                begin
                    cmd.step = 1'b1;
                end
                else if (slot_free)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
                else
                begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                if (slot_free)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ----- rtl/core/dad_dp.sv -----
`timescale 1ns / 1ps
// dad_dp: walk registers (year, month, day), month-length lookup, result register.
// Depends on dad_pkg.
module dad_dp
(
    input  logic                          clk,
    input  logic [dad_pkg::YEAR_W-1:0]    start_year,
    input  logic [dad_pkg::MONTH_W-1:0]   start_month,
    input  logic [dad_pkg::DAY_W-1:0]     start_day,
    input  logic [dad_pkg::ADD_W-1:0]     days_to_add,
    input  dad_pkg::dad_cmd_t             cmd,
    output dad_pkg::dad_stat_t            stat,
    output logic [dad_pkg::YEAR_W-1:0]    end_year,
    output logic [dad_pkg::MONTH_W-1:0]   end_month,
    output logic [dad_pkg::DAY_W-1:0]     end_day,
    output logic                          year_overflow
);

    logic [dad_pkg::WYEAR_W-1:0] year_reg, year_next;
    logic [dad_pkg::MONTH_W-1:0] month_reg, month_next;
    logic [dad_pkg::WDAY_W-1:0]  day_reg, day_next;
    logic [dad_pkg::YEAR_W-1:0]  end_year_reg;
    logic [dad_pkg::MONTH_W-1:0] end_month_reg;
    logic [dad_pkg::DAY_W-1:0]   end_day_reg;
    logic                        ovf_reg;
    logic [dad_pkg::DAY_W-1:0]   len;
    logic [dad_pkg::MONTH_W-1:0] month_clamped;
    logic                        ovf;

    assign len       = dad_pkg::month_len(month_reg, year_reg[1:0] == 2'b00);
    assign stat.fits = (day_reg <= dad_pkg::WDAY_W'(len));
    assign ovf       = (year_reg > dad_pkg::YEAR_MAX);

    // Month 0 reads as January, 13..15 as December.
    always_comb
    begin
        if (start_month < dad_pkg::JANUARY)
            month_clamped = dad_pkg::JANUARY;
        else if (start_month > dad_pkg::DECEMBER)
            month_clamped = dad_pkg::DECEMBER;
        else
            month_clamped = start_month;
    end

    always_comb
    begin
        year_next  = year_reg;
        month_next = month_reg;
        day_next   = day_reg;
        if (cmd.load_in)
        begin
            year_next  = dad_pkg::WYEAR_W'(start_year);
            month_next = month_clamped;
            day_next   = dad_pkg::WDAY_W'(start_day) + dad_pkg::WDAY_W'(days_to_add);
        end
        else if (cmd.step)
        begin
            day_next = day_reg - dad_pkg::WDAY_W'(len);
            if (month_reg == dad_pkg::DECEMBER)
            begin
                month_next = dad_pkg::JANUARY;
                year_next  = year_reg + dad_pkg::WYEAR_W'(1);
            end
            else
            begin
                month_next = month_reg + dad_pkg::MONTH_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        year_reg  <= year_next;
        month_reg <= month_next;
        day_reg   <= day_next;
        if (cmd.load_out)
        begin
            end_year_reg  <= ovf ? dad_pkg::YEAR_MAX[dad_pkg::YEAR_W-1:0]
                                 : year_reg[dad_pkg::YEAR_W-1:0];
            end_month_reg <= month_reg;
            end_day_reg   <= day_reg[dad_pkg::DAY_W-1:0];
            ovf_reg       <= ovf;
        end
    end

    assign end_year      = end_year_reg;
    assign end_month     = end_month_reg;
    assign end_day       = end_day_reg;
    assign year_overflow = ovf_reg;

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
// tb: self-checking bench for date_add_days, with random handshake pressure on both channels.
// Depends on dad_pkg (widths, month and year limits) and the date_add_days RTL.
module tb;

    // One start date plus the day count to add.
    typedef struct packed {
        logic [dad_pkg::YEAR_W-1:0]  year;
        logic [dad_pkg::MONTH_W-1:0] month;
        logic [dad_pkg::DAY_W-1:0]   day;
        logic [dad_pkg::ADD_W-1:0]   add;
    } date_item_t;

    // Normalized end date as the block should report it.
    typedef struct packed {
        logic [dad_pkg::YEAR_W-1:0]  year;
        logic [dad_pkg::MONTH_W-1:0] month;
        logic [dad_pkg::DAY_W-1:0]   day;
        logic                        ovf;
    } end_date_t;

    // Idle/stall percentages per phase: none, sender idle, receiver stall, both.
    localparam int SEND_IDLE_PCT[4]  = '{0, 47, 0, 17};
    localparam int RECV_STALL_PCT[4] = '{0, 0, 47, 17};
    // Worst walk is about 2200 months plus the load and hand-off overhead.
    localparam int DRAIN_CYCLES      = 2300;

    logic                          clk           = 1'b0;
    logic                          rst_n         = 1'b0;
    logic                          in_valid      = 1'b0;
    logic                          in_stall;
    logic [dad_pkg::YEAR_W-1:0]    start_year    = '0;
    logic [dad_pkg::MONTH_W-1:0]   start_month   = '0;
    logic [dad_pkg::DAY_W-1:0]     start_day     = '0;
    logic [dad_pkg::ADD_W-1:0]     days_to_add   = '0;
    logic                          out_valid;
    logic                          out_stall     = 1'b0;
    logic [dad_pkg::YEAR_W-1:0]    end_year;
    logic [dad_pkg::MONTH_W-1:0]   end_month;
    logic [dad_pkg::DAY_W-1:0]     end_day;
    logic                          year_overflow;

    date_item_t pending_dates[$];   // stimulus not yet put on the bus
    end_date_t  expected_dates[$];  // predicted end dates, oldest first

    int  n_total        = 0;
    int  items_sent     = 0;
    int  results_seen   = 0;
    int  errors         = 0;
    int  n_overflow     = 0;
    int  n_bad_month    = 0;
    int  n_long_walk    = 0;
    bit  in_hold        = 1'b0;   // an item sits on the bus waiting for acceptance
    bit  draining       = 1'b0;   // end of run: receiver never stalls

    always #2 clk = ~clk;

    date_add_days DUT
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .start_year    (start_year),
        .start_month   (start_month),
        .start_day     (start_day),
        .days_to_add   (days_to_add),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .end_year      (end_year),
        .end_month     (end_month),
        .end_day       (end_day),
        .year_overflow (year_overflow)
    );

    // Phase of the run from the number of items (or results) already through.
    function automatic int phase_of(input int idx);
        int p;
        begin
            p = (n_total == 0) ? 0 : (idx * 4) / n_total;
            return (p > 3) ? 3 : p;
        end
    endfunction

    // Month-by-month walk: out-of-range months are clamped first, then the
    // day sum is reduced by each month's length until it fits. The leap test
    // uses the true walked year; year saturates only at the very end.
    function automatic end_date_t walk_date(input date_item_t it);
        int unsigned year;
        int unsigned month;
        int unsigned day;
        int unsigned len;
        end_date_t   r;
        begin
            year  = it.year;
            month = it.month;
            day   = it.day + it.add;
            if (month < dad_pkg::JANUARY)
                month = dad_pkg::JANUARY;
            if (month > dad_pkg::DECEMBER)
                month = dad_pkg::DECEMBER;
            forever
            begin
                case (month)
                    dad_pkg::FEBRUARY: len = (year % 4 == 0) ? 29 : 28;
                    4, 6, 9, 11:       len = 30;
                    default:           len = 31;
                endcase
                if (day <= len)
                    break;
                day -= len;
                if (month == dad_pkg::DECEMBER)
                begin
                    month = dad_pkg::JANUARY;
                    year++;
                end
                else
                    month++;
            end
            r.ovf   = (year > dad_pkg::YEAR_MAX);
            r.year  = r.ovf ? dad_pkg::YEAR_W'(dad_pkg::YEAR_MAX) : dad_pkg::YEAR_W'(year);
            r.month = dad_pkg::MONTH_W'(month);
            r.day   = dad_pkg::DAY_W'(day);
            return r;
        end
    endfunction

    task automatic queue_date(input int y, input int m, input int d, input int n);
        date_item_t it;
        begin
            it.year  = dad_pkg::YEAR_W'(y);
            it.month = dad_pkg::MONTH_W'(m);
            it.day   = dad_pkg::DAY_W'(d);
            it.add   = dad_pkg::ADD_W'(n);
            pending_dates.push_back(it);
        end
    endtask

    // Driver: new item or idle at the falling edge; an item on the bus holds
    // until it has been accepted. While idle the payload carries noise.
    always @(negedge clk)
    begin : drive_dates
        date_item_t it;
        if (rst_n && !in_hold)
        begin
            if (pending_dates.size() != 0 &&
                $urandom_range(0, 99) >= SEND_IDLE_PCT[phase_of(items_sent)])
            begin
                it          = pending_dates.pop_front();
                start_year  <= it.year;
                start_month <= it.month;
                start_day   <= it.day;
                days_to_add <= it.add;
                in_valid    <= 1'b1;
                in_hold     = 1'b1;
            end
            else
            begin
                in_valid    <= 1'b0;
                start_year  <= dad_pkg::YEAR_W'($urandom);
                start_month <= dad_pkg::MONTH_W'($urandom);
                start_day   <= dad_pkg::DAY_W'($urandom);
                days_to_add <= dad_pkg::ADD_W'($urandom);
            end
        end
    end

    // Receiver back-pressure, released for the final drain.
    always @(negedge clk)
    begin
        if (!rst_n || draining)
            out_stall <= 1'b0;
        else
            out_stall <= ($urandom_range(0, 99) < RECV_STALL_PCT[phase_of(results_seen)]);
    end

    // Input acceptance: predict the end date from what the block actually took.
    always @(posedge clk)
    begin : take_date
        date_item_t it;
        end_date_t  want;
        if (rst_n && in_valid && !in_stall)
        begin
            it.year  = start_year;
            it.month = start_month;
            it.day   = start_day;
            it.add   = days_to_add;
            want     = walk_date(it);
            expected_dates.push_back(want);
            if (want.ovf)
                n_overflow++;
            if (it.month < dad_pkg::JANUARY || it.month > dad_pkg::DECEMBER)
                n_bad_month++;
            if (it.add >= 16'd32768)
                n_long_walk++;
            items_sent++;
            in_hold = 1'b0;
        end
    end

    // Result check against the oldest prediction.
    always @(posedge clk)
    begin : check_date
        end_date_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_dates.size() == 0)
            begin
                $error("unexpected result: %0d-%0d-%0d ovf=%0b",
                       end_year, end_month, end_day, year_overflow);
                errors++;
            end
            else
            begin
                want = expected_dates.pop_front();
                results_seen++;
                if (end_year !== want.year)
                begin
                    $error("end_year mismatch: expected %0d, got %0d", want.year, end_year);
                    errors++;
                end
                if (end_month !== want.month)
                begin
                    $error("end_month mismatch: expected %0d, got %0d", want.month, end_month);
                    errors++;
                end
                if (end_day !== want.day)
                begin
                    $error("end_day mismatch: expected %0d, got %0d", want.day, end_day);
                    errors++;
                end
                if (year_overflow !== want.ovf)
                begin
                    $error("year_overflow mismatch: expected %0b, got %0b",
                           want.ovf, year_overflow);
                    errors++;
                end
            end
        end
    end

    initial
    begin : stimulus
        int r;
        int k;
        date_item_t it;

        // Directed: leap rules, year wrap, field extremes, clamped months,
        // oversized start days, day zero, and both overflow sources.
        queue_date(2024, 2, 28, 1);        // into Feb 29, leap year
        queue_date(2023, 2, 28, 1);        // Feb 28 -> Mar 1
        queue_date(1900, 2, 28, 1);        // no century rule: 1900 is leap here
        queue_date(2024, 1, 31, 29);       // walk into leap February 29
        queue_date(0, 1, 1, 0);            // minimum year, January 1, nothing to add
        queue_date(0, 0, 0, 0);            // month zero, day zero, nothing to add
        queue_date(0, 0, 0, 1);            // day zero plus one
        queue_date(2023, 13, 5, 0);        // month above December
        queue_date(2023, 15, 31, 0);
        queue_date(2023, 2, 31, 0);        // start day past month end
        queue_date(2023, 4, 31, 0);
        queue_date(2021, 12, 31, 1);       // year wrap
        queue_date(1, 1, 1, 65535);        // longest add
        queue_date(9999, 1, 1, 0);         // top year, no overflow
        queue_date(9999, 12, 31, 1);       // walks past 9999
        queue_date(9990, 1, 1, 3650);
        queue_date(10000, 6, 15, 10);      // start year already out of range
        queue_date(16383, 15, 31, 65535);  // all fields at maximum
        queue_date(10922, 10, 21, 43690);  // alternating bit patterns
        queue_date(5461, 5, 10, 21845);
        queue_date(5000, 3, 1, 365);

        // Random: mostly well-formed dates with short adds (cheap walks),
        // then raw field values, then full-range adds and edge years.
        for (k = 0; k < 230; k++)
        begin
            r = $urandom_range(0, 99);
            if (r < 55)
            begin
                it.year  = dad_pkg::YEAR_W'($urandom_range(0, 9999));
                it.month = dad_pkg::MONTH_W'($urandom_range(1, 12));
                it.day   = dad_pkg::DAY_W'($urandom_range(1, 28));
                it.add   = dad_pkg::ADD_W'($urandom_range(0, 1500));
            end
            else if (r < 72)
            begin
                it.year  = dad_pkg::YEAR_W'($urandom);
                it.month = dad_pkg::MONTH_W'($urandom);
                it.day   = dad_pkg::DAY_W'($urandom);
                it.add   = dad_pkg::ADD_W'($urandom_range(0, 3000));
            end
            else if (r < 88)
            begin
                it.year  = dad_pkg::YEAR_W'($urandom);
                it.month = dad_pkg::MONTH_W'($urandom);
                it.day   = dad_pkg::DAY_W'($urandom);
                it.add   = dad_pkg::ADD_W'($urandom);
            end
            else
            begin
                it.year  = ($urandom_range(0, 1) != 0)
                           ? dad_pkg::YEAR_W'($urandom_range(9900, 9999))
                           : dad_pkg::YEAR_W'($urandom_range(16000, 16383));
                it.month = dad_pkg::MONTH_W'($urandom);
                it.day   = dad_pkg::DAY_W'($urandom_range(27, 31));
                it.add   = ($urandom_range(0, 1) != 0) ? dad_pkg::ADD_W'($urandom)
                                                       : dad_pkg::ADD_W'($urandom_range(0, 400));
            end
            pending_dates.push_back(it);
        end
        n_total = pending_dates.size();

        repeat (8) @(negedge clk);
        rst_n = 1'b1;

        // Everything sent and every predicted date seen.
        while (pending_dates.size() != 0 || in_hold || expected_dates.size() != 0)
            @(negedge clk);
        // Watch for stray results for one worst-case walk.
        draining = 1'b1;
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Ran %0d items through four handshake phases, %0d results checked.",
                 items_sent, results_seen);
        $display("Of these: %0d year overflows, %0d clamped months, %0d adds of 32768+ days.",
                 n_overflow, n_bad_month, n_long_walk);
        if (errors == 0)
            $display("date_add_days verification clean");
        else
            $display("date_add_days verification failed");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run (every item a full walk
    // plus stalls).
    initial
    begin
        #20_000_000;
        $display("date_add_days verification failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/dad_pkg.sv
rtl/core/dad_ctrl.sv
rtl/core/dad_dp.sv
rtl/core/date_add_days.sv
tb/sv/tb.sv
